// ===== rtl/isot_pkg.sv =====
`timescale 1ns / 1ps

package isot_pkg;

    localparam int unsigned NUM_BINS = 256;
    localparam int unsigned BIN_W = 8;
    localparam int unsigned FRAC_W = 8;
    localparam int unsigned Q_W = 16;
    localparam int unsigned ITER_W = 16;
    localparam int unsigned CNT_OUT_W = 17;
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned STEP_W = $clog2(DIV_STEPS);

    localparam logic [ITER_W-1:0] MAX_ITER_RESET = 16'd1000;
    localparam logic [BIN_W-1:0] INIT_THR_RESET = 8'd128;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic REG_MAX_ITER = 1'b0;
    localparam logic REG_INIT_THR = 1'b1;

    typedef struct packed {
        logic [BIN_W-1:0] pixel;
        logic             last_pixel;
    } pixel_req_t;

    typedef struct packed {
        logic [Q_W-1:0]       threshold_q8;
        logic [CNT_OUT_W-1:0] left_count;
        logic [CNT_OUT_W-1:0] right_count;
        logic [ITER_W-1:0]    passes_used;
        logic                 converged;
    } result_t;

    typedef struct packed {
        logic [BIN_W-1:0] pixel;
        logic             counted;
        logic             last;
    } queue_entry_t;

    typedef struct packed {
        logic [ITER_W-1:0] max_iter;
        logic [BIN_W-1:0]  init_thr;
    } cfg_t;

endpackage

// ===== rtl/isodata_iterative_threshold.sv =====
`timescale 1ns / 1ps

// iterative isodata threshold of one 8-bit gray image
// px channel: one request per pixel (pixel, last_pixel), valid/ready
// res channel: one result per image after its last pixel, valid/ready
// apb port: reg 0 at 0x0 max_iterations, reg 1 at 0x4 initial_threshold;
//   write only between images
// throughput: one pixel per cycle while an image streams in, once the previous
//   image's result is registered and the histogram clear is done
// each pass is a 256-bin histogram sweep on the single memory read port,
//   then a serial shift-add multiply and a 16-step restoring divide;
//   counts are clog2(MAX_PIXELS + 1) bits wide
// after a result is registered, the histogram is cleared bin by bin,
//   during which no pixel is taken
// reset: registers return to 1000 and 128, then the same clear
//   runs before the first pixel is taken
// a stalled res channel holds the result; pixels of the next image still
//   enter once the clear is done, and the next result waits for the slot

module isodata_iterative_threshold #(
    parameter int unsigned MAX_PIXELS = 65536
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            px_valid,
    output logic                            px_ready,
    input  isot_pkg::pixel_req_t            px,
    output logic                            res_valid,
    input  logic                            res_ready,
    output isot_pkg::result_t               res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [isot_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [isot_pkg::APB_DATA_W-1:0] pwdata,
    output logic [isot_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import isot_pkg::*;

    cfg_t                   cfg_reg, cfg_next;
    logic                   reg_sel;
    logic                   cfg_write;
    logic                   hold;
    logic                   q_valid;
    logic                   q_ready;
    queue_entry_t           q_entry;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[APB_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_sel)
                REG_MAX_ITER: cfg_next.max_iter = pwdata[ITER_W-1:0];
                REG_INIT_THR: cfg_next.init_thr = pwdata[BIN_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MAX_ITER: prdata = APB_DATA_W'(cfg_reg.max_iter);
            REG_INIT_THR: prdata = APB_DATA_W'(cfg_reg.init_thr);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_iter <= MAX_ITER_RESET;
            cfg_reg.init_thr <= INIT_THR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    isot_front #(
        .MAX_PIXELS(MAX_PIXELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .px_valid (px_valid),
        .px_ready (px_ready),
        .px       (px),
        .hold     (hold),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_entry  (q_entry)
    );

    isot_back #(
        .MAX_PIXELS(MAX_PIXELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_entry   (q_entry),
        .clearing  (hold),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

// ===== rtl/isot_front.sv =====
`timescale 1ns / 1ps

module isot_front #(
    parameter int unsigned MAX_PIXELS = 65536
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   px_valid,
    output logic                   px_ready,
    input  isot_pkg::pixel_req_t   px,
    input  logic                   hold,
    output logic                   q_valid,
    input  logic                   q_ready,
    output isot_pkg::queue_entry_t q_entry
);
    import isot_pkg::*;

    localparam int unsigned PW = $clog2(MAX_PIXELS + 1);
    localparam logic [PW-1:0] MAX_CNT = PW'(MAX_PIXELS);
    localparam logic [PW-1:0] CNT_ONE = PW'(1);
    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);
    localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

    queue_entry_t      fifo_q [DEPTH];
    queue_entry_t      new_entry;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [PW-1:0]     count_reg, count_next;
    logic              push;
    logic              pop;

    assign px_ready = (fill_reg != FILL_FULL) && !hold;
    assign push     = px_valid && px_ready;
    assign q_valid  = (fill_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_entry  = fifo_q[rd_ptr_reg];

    // pixels past the image limit still travel, but are not counted
    always_comb
    begin
        new_entry.pixel   = px.pixel;
        new_entry.counted = (count_reg < MAX_CNT);
        new_entry.last    = px.last_pixel;
    end

    always_comb
    begin
        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_ONE;
            if (px.last_pixel)
            begin
                count_next = '0;
            end
            else if (new_entry.counted)
            begin
                count_next = count_reg + CNT_ONE;
            end
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_ONE;
        end
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + FILL_ONE;
            2'b01:   fill_next = fill_reg - FILL_ONE;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_q[wr_ptr_reg] <= new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== rtl/isot_arith.sv =====
`timescale 1ns / 1ps

module isot_arith #(
    parameter int unsigned PW = 17
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [PW+7:0]            sum_left,
    input  logic [PW+7:0]            sum_right,
    input  logic [PW-1:0]            cnt_left,
    input  logic [PW-1:0]            cnt_right,
    output logic                     done,
    output logic [isot_pkg::Q_W-1:0] quotient
);
    import isot_pkg::*;

    localparam int unsigned SW = PW + BIN_W;
    localparam int unsigned PRW = SW + PW;
    localparam int unsigned DW = 2 * PW;
    localparam int unsigned NW = PRW + 1 + FRAC_W;
    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_SUM  = 4'b0100,
        A_DIV  = 4'b1000
    } arith_state_t;

    arith_state_t      st_reg, st_next;
    logic              done_reg, done_next;
    logic [PRW-1:0]    m_sl_reg, m_sl_next, m_sr_reg, m_sr_next;
    logic [DW-1:0]     m_nl_reg, m_nl_next;
    logic [PW-1:0]     b_nr_reg, b_nr_next, b_nl_reg, b_nl_next;
    logic [PRW-1:0]    p1_reg, p1_next, p2_reg, p2_next;
    logic [DW-1:0]     p3_reg, p3_next;
    logic [NW-1:0]     rem_reg, rem_next, dsh_reg, dsh_next;
    logic [Q_W-1:0]    quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              ge;

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign ge       = (rem_reg >= dsh_reg);

    // shift-add products sl*nr, sr*nl, nl*nr, then restoring divide
    always_comb
    begin
        st_next   = st_reg;
        done_next = 1'b0;
        m_sl_next = m_sl_reg;
        m_sr_next = m_sr_reg;
        m_nl_next = m_nl_reg;
        b_nr_next = b_nr_reg;
        b_nl_next = b_nl_reg;
        p1_next   = p1_reg;
        p2_next   = p2_reg;
        p3_next   = p3_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        unique case (st_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    m_sl_next = PRW'(sum_left);
                    m_sr_next = PRW'(sum_right);
                    m_nl_next = DW'(cnt_left);
                    b_nr_next = cnt_right;
                    b_nl_next = cnt_left;
                    p1_next   = '0;
                    p2_next   = '0;
                    p3_next   = '0;
                    st_next   = A_MUL;
                end
            end
            A_MUL:
            begin
                if (b_nr_reg == '0 && b_nl_reg == '0)
                begin
                    st_next = A_SUM;
                end
                else
                begin
                    p1_next   = p1_reg + (b_nr_reg[0] ? m_sl_reg : '0);
                    p2_next   = p2_reg + (b_nl_reg[0] ? m_sr_reg : '0);
                    p3_next   = p3_reg + (b_nr_reg[0] ? m_nl_reg : '0);
                    m_sl_next = m_sl_reg << 1;
                    m_sr_next = m_sr_reg << 1;
                    m_nl_next = m_nl_reg << 1;
                    b_nr_next = b_nr_reg >> 1;
                    b_nl_next = b_nl_reg >> 1;
                end
            end
            A_SUM:
            begin
                rem_next  = (NW'(p1_reg) + NW'(p2_reg)) << FRAC_W;
                // divisor 2*nl*nr aligned to the top quotient bit
                dsh_next  = NW'(p3_reg) << Q_W;
                quo_next  = '0;
                step_next = '0;
                st_next   = A_DIV;
            end
            A_DIV:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                quo_next  = {quo_reg[Q_W-2:0], ge};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + STEP_ONE;
                if (step_reg == LAST_STEP)
                begin
                    done_next = 1'b1;
                    st_next   = A_IDLE;
                end
            end
            default:
            begin
                st_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        m_sl_reg <= m_sl_next;
        m_sr_reg <= m_sr_next;
        m_nl_reg <= m_nl_next;
        b_nr_reg <= b_nr_next;
        b_nl_reg <= b_nl_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        p3_reg   <= p3_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= A_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

endmodule

// ===== rtl/isot_back.sv =====
`timescale 1ns / 1ps

module isot_back #(
    parameter int unsigned MAX_PIXELS = 65536
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  isot_pkg::cfg_t         cfg,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  isot_pkg::queue_entry_t q_entry,
    output logic                   clearing,
    output logic                   res_valid,
    input  logic                   res_ready,
    output isot_pkg::result_t      res
);
    import isot_pkg::*;

    localparam int unsigned PW = $clog2(MAX_PIXELS + 1);
    localparam int unsigned SW = PW + BIN_W;
    localparam int unsigned IW = BIN_W + 1;
    localparam logic [PW-1:0] MAX_CNT = PW'(MAX_PIXELS);
    localparam logic [PW-1:0] CNT_ONE = PW'(1);
    localparam logic [IW-1:0] IDX_ONE = IW'(1);
    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(NUM_BINS - 1);
    localparam logic [ITER_W-1:0] ITER_ONE = ITER_W'(1);

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_ACCUM   = 6'b000010,
        ST_DRAIN   = 6'b000100,
        ST_SWEEP   = 6'b001000,
        ST_MATH    = 6'b010000,
        ST_PUBLISH = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     hist_mem [NUM_BINS];
    logic              mem_we;
    logic [BIN_W-1:0]  mem_waddr, mem_raddr;
    logic [PW-1:0]     mem_wdata, mem_rdata_reg;
    logic              pop;
    logic              s1_valid_reg;
    logic [BIN_W-1:0]  s1_pixel_reg;
    logic              s1_counted_reg;
    logic              fwd_valid_reg;
    logic [BIN_W-1:0]  fwd_addr_reg;
    logic [PW-1:0]     fwd_data_reg;
    logic              inc_we;
    logic [PW-1:0]     inc_base;
    logic [PW-1:0]     total_reg, total_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              rd_v_reg, rd_v_next;
    logic [BIN_W-1:0]  rd_bin_reg;
    logic              p_v_reg;
    logic              p_left_reg;
    logic [PW-1:0]     p_cnt_reg;
    logic [SW-1:0]     p_prod_reg;
    logic [PW-1:0]     cl_reg, cl_next;
    logic [SW-1:0]     sl_reg, sl_next, sr_reg, sr_next;
    logic [BIN_W-1:0]  cur_reg, cur_next;
    logic [ITER_W-1:0] pass_reg, pass_next, pass_inc, limit;
    logic [PW-1:0]     nl_reg, nl_next, nr_reg, nr_next, nr_raw, nl_c, nr_c;
    logic [Q_W-1:0]    tq_reg, tq_next;
    logic              conv_reg, conv_next;
    logic              sweep_init, sweep_done, pub_fire, finish, conv_c;
    logic              arith_start, arith_done;
    logic [Q_W-1:0]    arith_quo;
    result_t           res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    assign q_ready   = (state_reg == ST_ACCUM);
    assign pop       = q_valid && q_ready;
    assign clearing  = (state_reg == ST_CLEAR);
    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    // histogram read-modify-write, forwarding the previous increment's written count
    assign inc_we    = s1_valid_reg && s1_counted_reg;
    assign inc_base  = (fwd_valid_reg && fwd_addr_reg == s1_pixel_reg) ? fwd_data_reg
                                                                       : mem_rdata_reg;
    assign mem_raddr = (state_reg == ST_SWEEP) ? idx_reg[BIN_W-1:0] : q_entry.pixel;
    assign mem_we    = (state_reg == ST_CLEAR) || inc_we;
    assign mem_waddr = (state_reg == ST_CLEAR) ? idx_reg[BIN_W-1:0] : s1_pixel_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : inc_base + CNT_ONE;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= hist_mem[mem_raddr];
    end

    // class split of one pass
    assign nr_raw     = total_reg - cl_reg;
    assign nl_c       = (cl_reg == '0) ? CNT_ONE : cl_reg;
    assign nr_c       = (nr_raw == '0) ? CNT_ONE : nr_raw;
    assign limit      = (cfg.max_iter == '0) ? ITER_ONE : cfg.max_iter;
    assign pass_inc   = pass_reg + ITER_ONE;
    assign conv_c     = (arith_quo[Q_W-1:FRAC_W] == cur_reg);
    assign finish     = conv_c || (pass_inc >= limit);
    assign sweep_done = (state_reg == ST_SWEEP) && idx_reg[BIN_W] && !rd_v_reg && !p_v_reg;
    assign sweep_init = (state_reg == ST_DRAIN)
                        || ((state_reg == ST_MATH) && arith_done && !finish);
    assign pub_fire   = !res_valid_reg || res_ready;
    assign rd_v_next  = (state_reg == ST_SWEEP) && !idx_reg[BIN_W];

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        cl_next        = cl_reg;
        sl_next        = sl_reg;
        sr_next        = sr_reg;
        cur_next       = cur_reg;
        pass_next      = pass_reg;
        nl_next        = nl_reg;
        nr_next        = nr_reg;
        tq_next        = tq_reg;
        conv_next      = conv_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        arith_start    = 1'b0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (inc_we)
        begin
            total_next = total_reg + CNT_ONE;
        end
        if (p_v_reg)
        begin
            if (p_left_reg)
            begin
                cl_next = cl_reg + p_cnt_reg;
                sl_next = sl_reg + p_prod_reg;
            end
            else
            begin
                sr_next = sr_reg + p_prod_reg;
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                idx_next = idx_reg + IDX_ONE;
                if (idx_reg[BIN_W-1:0] == BIN_LAST)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                if (pop && q_entry.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cur_next   = cfg.init_thr;
                pass_next  = '0;
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (!idx_reg[BIN_W])
                begin
                    idx_next = idx_reg + IDX_ONE;
                end
                else if (sweep_done)
                begin
                    nl_next     = nl_c;
                    nr_next     = nr_c;
                    arith_start = 1'b1;
                    state_next  = ST_MATH;
                end
            end
            ST_MATH:
            begin
                if (arith_done)
                begin
                    tq_next   = arith_quo;
                    pass_next = pass_inc;
                    conv_next = conv_c;
                    if (finish)
                    begin
                        state_next = ST_PUBLISH;
                    end
                    else
                    begin
                        cur_next   = arith_quo[Q_W-1:FRAC_W];
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_PUBLISH:
            begin
                if (pub_fire)
                begin
                    res_next.threshold_q8 = tq_reg;
                    res_next.left_count   = CNT_OUT_W'(nl_reg);
                    res_next.right_count  = CNT_OUT_W'(nr_reg);
                    res_next.passes_used  = pass_reg;
                    res_next.converged    = conv_reg;
                    res_valid_next        = 1'b1;
                    idx_next              = '0;
                    total_next            = '0;
                    state_next            = ST_CLEAR;
                end
            end
            default:
            begin
                idx_next   = '0;
                state_next = ST_CLEAR;
            end
        endcase

        if (sweep_init)
        begin
            idx_next = '0;
            cl_next  = '0;
            sl_next  = '0;
            sr_next  = '0;
        end
    end

    isot_arith #(
        .PW(PW)
    ) u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (arith_start),
        .sum_left  (sl_reg),
        .sum_right (sr_reg),
        .cnt_left  (nl_c),
        .cnt_right (nr_c),
        .done      (arith_done),
        .quotient  (arith_quo)
    );

    always_ff @(posedge clk)
    begin
        s1_pixel_reg   <= q_entry.pixel;
        s1_counted_reg <= q_entry.counted;
        fwd_addr_reg   <= s1_pixel_reg;
        fwd_data_reg   <= mem_wdata;
        rd_bin_reg     <= idx_reg[BIN_W-1:0];
        p_left_reg     <= (rd_bin_reg <= cur_reg);
        p_cnt_reg      <= mem_rdata_reg;
        p_prod_reg     <= SW'(mem_rdata_reg) * SW'(rd_bin_reg);
        cl_reg         <= cl_next;
        sl_reg         <= sl_next;
        sr_reg         <= sr_next;
        cur_reg        <= cur_next;
        nl_reg         <= nl_next;
        nr_reg         <= nr_next;
        tq_reg         <= tq_next;
        conv_reg       <= conv_next;
        res_reg        <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            total_reg     <= '0;
            pass_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            rd_v_reg      <= 1'b0;
            p_v_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            total_reg     <= total_next;
            pass_reg      <= pass_next;
            s1_valid_reg  <= pop;
            fwd_valid_reg <= inc_we;
            rd_v_reg      <= rd_v_next;
            p_v_reg       <= rd_v_reg;
            res_valid_reg <= res_valid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> !mem_we)
        else $error("histogram written during a threshold sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= MAX_CNT)
        else $error("pixel total above image limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        arith_done |-> (state_reg == ST_MATH))
        else $error("divider finished outside of a pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUBLISH && pub_fire) |=> (state_reg == ST_CLEAR && res_valid_reg))
        else $error("result not held after publish");

endmodule
